[rtl/core/nvs_pkg.sv]
// shared types and constants of the nearest vector search
package nvs_pkg;

  localparam int NVS_MAX_LENGTH = 64;
  localparam int NVS_MAX_ROWS   = 1024;
  localparam int NVS_QDEPTH     = 4;
  localparam int NVS_QCW        = 3;
  localparam int NVS_ROW_W      = 16;
  localparam int NVS_OUT_ROW_W  = 10;

  typedef enum logic [1:0] {
    METRIC_MANHATTAN = 2'd0,
    METRIC_EUCLID    = 2'd1,
    METRIC_COSINE    = 2'd2,
    METRIC_COSINE_X  = 2'd3
  } nvs_metric_e;

  typedef enum logic {
    CFG_METRIC = 1'b0,
    CFG_LENGTH = 1'b1
  } nvs_cfg_e;

  typedef struct packed {
    logic                        cos;
    logic signed [47:0]          accum;
    logic [39:0]                 qn;
    logic [39:0]                 rn;
    logic [NVS_ROW_W-1:0]        row;
    logic                        fresh;
    logic                        last;
  } nvs_rec_t;

endpackage

[rtl/core/nvs_ram.sv]
// generic single write port ram with registered read
module nvs_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/nvs_front.sv]
// front end: config, query load and per element accumulation
module nvs_front import nvs_pkg::*; #(
  parameter int MaxLength = NVS_MAX_LENGTH,
  parameter int MaxRows   = NVS_MAX_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [15:0] value_i,
  input  logic               last_row_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic [NVS_QCW-1:0] q_count_i,
  output logic               push_o,
  output nvs_rec_t           rec_o
);

  localparam int LW = $clog2(MaxLength + 1);
  localparam int AW = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int RW = $clog2(MaxRows);

  logic [1:0]  metric_q;
  logic [6:0]  vlen_q;
  logic        searching_q, searching_d;
  logic [LW-1:0] qlen_q, qlen_d, ecnt_q, ecnt_d;
  logic [RW-1:0] row_q, row_d;
  logic        fresh_q, fresh_d;
  logic [39:0] qn_q, qn_d;

  logic        s2_valid_q, s2_first_q, s2_qvalid_q, s2_end_q, s2_fresh_q, s2_last_q;
  logic signed [15:0] s2_v_q;
  logic [1:0]  s2_mode_q;
  logic [RW-1:0] s2_row_q;
  logic [39:0] s2_qn_q;
  logic signed [47:0] accum_q, accum_d;
  logic [39:0] rn_q, rn_d;

  logic          acc;
  logic [LW-1:0] len, qlen_b, ecnt_b, ecnt_n;
  logic [RW-1:0] row_b;
  logic          fresh_b, row_end;
  logic [39:0]   qn_b;
  logic signed [31:0] vsq_in;
  logic          we;
  logic [15:0]   rdata;

  logic signed [15:0] q_s2;
  logic signed [16:0] diff, mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [31:0] vsq_s2;
  logic signed [47:0] term;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (({1'b0, q_count_i}) + {{NVS_QCW{1'b0}}, s2_valid_q & s2_end_q})
                       >= (NVS_QCW + 1)'(NVS_QDEPTH);
  assign acc = in_valid_i & ~in_stall_o;

  always_comb begin
    if (vlen_q == 7'd0) begin
      len = LW'(1);
    end else if (32'(vlen_q) > MaxLength) begin
      len = LW'(MaxLength);
    end else begin
      len = LW'(vlen_q);
    end
  end

  assign vsq_in  = value_i * value_i;

  always_comb begin
    searching_d = searching_q;
    qlen_d      = qlen_q;
    ecnt_d      = ecnt_q;
    row_d       = row_q;
    fresh_d     = fresh_q;
    qn_d        = qn_q;
    we          = 1'b0;
    qlen_b      = qlen_q;
    qn_b        = qn_q;
    ecnt_b      = ecnt_q;
    row_b       = row_q;
    fresh_b     = fresh_q;
    ecnt_n      = ecnt_q + LW'(1);
    row_end     = 1'b0;
    if (acc && !cmd_i) begin
      if (searching_q) begin
        searching_d = 1'b0;
        qlen_b      = '0;
        qn_b        = '0;
        ecnt_d      = '0;
        row_d       = '0;
        fresh_d     = 1'b1;
      end
      qlen_d = qlen_b;
      qn_d   = qn_b;
      if (qlen_b < len) begin
        we     = 1'b1;
        qn_d   = qn_b + 40'(unsigned'(vsq_in));
        qlen_d = qlen_b + LW'(1);
      end
    end else if (acc) begin
      if (!searching_q) begin
        searching_d = 1'b1;
        ecnt_b      = '0;
        row_b       = '0;
        fresh_b     = 1'b1;
      end
      ecnt_n  = ecnt_b + LW'(1);
      row_end = ecnt_n >= len;
      if (row_end) begin
        ecnt_d  = '0;
        row_d   = last_row_i ? '0 : ((32'(row_b) == MaxRows - 1) ? '0 : row_b + RW'(1));
        fresh_d = last_row_i;
      end else begin
        ecnt_d  = ecnt_n;
        row_d   = row_b;
        fresh_d = fresh_b;
      end
    end
  end

  nvs_ram #(.Width(16), .Depth(MaxLength), .AddrW(AW)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(qlen_b)),
    .wdata_i (value_i),
    .raddr_i (AW'(ecnt_b)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q    <= METRIC_MANHATTAN;
      vlen_q      <= 7'd64;
      searching_q <= 1'b0;
      qlen_q      <= '0;
      ecnt_q      <= '0;
      row_q       <= '0;
      fresh_q     <= 1'b1;
      qn_q        <= '0;
      s2_valid_q  <= 1'b0;
      accum_q     <= '0;
      rn_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_METRIC: metric_q <= cfg_data_i[1:0];
          CFG_LENGTH: vlen_q   <= cfg_data_i;
          default: ;
        endcase
      end
      searching_q <= searching_d;
      qlen_q      <= qlen_d;
      ecnt_q      <= ecnt_d;
      row_q       <= row_d;
      fresh_q     <= fresh_d;
      qn_q        <= qn_d;
      s2_valid_q  <= acc & cmd_i;
      if (s2_valid_q) begin
        accum_q <= accum_d;
        rn_q    <= rn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && cmd_i) begin
      s2_first_q  <= ecnt_b == '0;
      s2_qvalid_q <= ecnt_b < qlen_q;
      s2_end_q    <= row_end;
      s2_fresh_q  <= fresh_b;
      s2_last_q   <= last_row_i;
      s2_v_q      <= value_i;
      s2_mode_q   <= metric_q;
      s2_row_q    <= row_b;
      s2_qn_q     <= qn_q;
    end
  end

  assign q_s2   = s2_qvalid_q ? signed'(rdata) : 16'sd0;
  assign diff   = 17'(q_s2) - 17'(s2_v_q);
  assign mul_a  = (s2_mode_q == METRIC_EUCLID) ? diff : 17'(q_s2);
  assign mul_b  = (s2_mode_q == METRIC_EUCLID) ? diff : 17'(s2_v_q);
  assign prod   = mul_a * mul_b;
  assign vsq_s2 = s2_v_q * s2_v_q;

  always_comb begin
    case (s2_mode_q)
      METRIC_MANHATTAN: term = 48'(diff[16] ? -diff : diff);
      default:          term = 48'(prod);
    endcase
    accum_d = (s2_first_q ? 48'sd0 : accum_q) + term;
    rn_d    = (s2_first_q ? 40'd0 : rn_q) + 40'(unsigned'(vsq_s2));
  end

  assign push_o      = s2_valid_q & s2_end_q;
  assign rec_o.cos   = s2_mode_q[1];
  assign rec_o.accum = accum_d;
  assign rec_o.qn    = s2_qn_q;
  assign rec_o.rn    = rn_d;
  assign rec_o.row   = NVS_ROW_W'(s2_row_q);
  assign rec_o.fresh = s2_fresh_q;
  assign rec_o.last  = s2_last_q;

endmodule

[rtl/core/nvs_queue.sv]
// short fifo of finished row records between front and back
module nvs_queue import nvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nvs_rec_t           rec_i,
  input  logic               pop_i,
  output nvs_rec_t           head_o,
  output logic               empty_o,
  output logic [NVS_QCW-1:0] count_o
);

  localparam int PW = $clog2(NVS_QDEPTH);

  nvs_rec_t           buf_q [NVS_QDEPTH];
  logic [PW-1:0]      wp_q, rp_q;
  logic [NVS_QCW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i)  rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + NVS_QCW'(push_i) - NVS_QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= rec_i;
  end

  assign head_o  = buf_q[rp_q];
  assign empty_o = cnt_q == '0;
  assign count_o = cnt_q;

endmodule

[rtl/core/nvs_back.sv]
// back end: cosine root and divide, best row tracking, result register
module nvs_back import nvs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nvs_rec_t                 head_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [47:0]       score_o,
  output logic [NVS_OUT_ROW_W-1:0] row_index_o,
  output logic                     zero_norm_o,
  output logic [NVS_OUT_ROW_W-1:0] best_index_o,
  output logic                     done_res_o
);

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_MUL, S_DIV, S_FIN} state_e;

  typedef struct packed {
    logic [55:0] x;
    logic [55:0] r;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s, input logic [55:0] b);
    sq_t        o;
    logic [56:0] sum;
    sum = {1'b0, s.r} + {1'b0, b};
    if ({1'b0, s.x} >= sum) begin
      o.x = s.x - sum[55:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  state_e             state_q;
  nvs_rec_t           rec_q;
  sq_t                sa_q, sb_q;
  logic [55:0]        bit_q;
  logic [5:0]         cnt_q;
  logic [55:0]        p_q;
  logic [56:0]        r_q;
  logic [46:0]        quo_q;
  logic signed [47:0] res_q;
  logic               zero_q;
  logic               bv_q;
  logic signed [47:0] best_q;
  logic [NVS_ROW_W-1:0] best_row_q;
  logic               out_valid_q;
  logic signed [47:0] score_q;
  logic [NVS_OUT_ROW_W-1:0] row_idx_q, best_idx_q;
  logic               zero_out_q, done_q;

  logic               head_zero;
  logic [47:0]        mag;
  logic [56:0]        r2;
  logic [30:0]        qc;
  logic               bv, better;

  assign head_zero = head_i.cos && (head_i.qn == '0 || head_i.rn == '0);
  assign pop_o     = (state_q == S_IDLE) && !empty_i;
  assign mag       = rec_q.accum[47] ? 48'(-rec_q.accum) : 48'(rec_q.accum);
  assign r2        = {r_q[55:0], 1'b0};
  assign qc        = (quo_q > 47'(32'h4000_0000)) ? 31'h4000_0000 : quo_q[30:0];

  assign bv = rec_q.fresh ? 1'b0 : bv_q;
  always_comb begin
    if (rec_q.cos) begin
      better = !zero_q && (!bv || res_q > best_q);
    end else begin
      better = !bv || res_q < best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bv_q        <= 1'b0;
      best_q      <= '0;
      best_row_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            rec_q  <= head_i;
            zero_q <= head_zero;
            if (!head_i.cos || head_zero) begin
              res_q   <= head_i.cos ? 48'sd0 : head_i.accum;
              state_q <= S_FIN;
            end else begin
              sa_q    <= '{x: {head_i.qn, 16'd0}, r: '0};
              sb_q    <= '{x: {head_i.rn, 16'd0}, r: '0};
              bit_q   <= 56'd1 << 54;
              state_q <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          sa_q  <= sq_step(sa_q, bit_q);
          sb_q  <= sq_step(sb_q, bit_q);
          bit_q <= bit_q >> 2;
          if (bit_q == 56'd1) state_q <= S_MUL;
        end
        S_MUL: begin
          p_q     <= sa_q.r[27:0] * sb_q.r[27:0];
          state_q <= S_DIV;
          cnt_q   <= 6'd0;
          r_q     <= 57'(mag);
          quo_q   <= '0;
        end
        S_DIV: begin
          if (cnt_q == 6'd0 && (p_q == '0 || r_q >= {1'b0, p_q})) begin
            res_q   <= rec_q.accum[47] ? -48'sd1073741824 : 48'sd1073741824;
            state_q <= S_FIN;
          end else begin
            if (r2 >= {1'b0, p_q}) begin
              r_q   <= r2 - {1'b0, p_q};
              quo_q <= {quo_q[45:0], 1'b1};
            end else begin
              r_q   <= r2;
              quo_q <= {quo_q[45:0], 1'b0};
            end
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd46) begin
              res_q   <= rec_q.accum[47] ? -48'(qc) : 48'(qc);
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            score_q     <= res_q;
            row_idx_q   <= NVS_OUT_ROW_W'(rec_q.row);
            zero_out_q  <= zero_q;
            done_q      <= rec_q.last;
            if (better) begin
              bv_q       <= 1'b1;
              best_q     <= res_q;
              best_row_q <= rec_q.row;
              best_idx_q <= NVS_OUT_ROW_W'(rec_q.row);
            end else begin
              bv_q       <= bv;
              best_idx_q <= bv ? NVS_OUT_ROW_W'(best_row_q) : '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign score_o      = score_q;
  assign row_index_o  = row_idx_q;
  assign zero_norm_o  = zero_out_q;
  assign best_index_o = best_idx_q;
  assign done_res_o   = done_q;

endmodule

[rtl/core/nearest_vector_search.sv]
// top level of the nearest vector search
// path: a distance row result passes the front end stage, row queue, back end record
// and output registers; cosine adds 28 root steps, a multiply and up to 47 divide steps
// throughput: one element per cycle while in_stall_o is low; the back end takes a new
// row only after the last one, and a four-entry row queue absorbs bursts of short rows
// reset: asynchronous, clears control state, metric 0 and length 64; query store is unset
module nearest_vector_search import nvs_pkg::*; #(
  parameter int MaxLength = NVS_MAX_LENGTH,
  parameter int MaxRows   = NVS_MAX_ROWS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic signed [15:0]       value_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [47:0]       score_o,
  output logic [NVS_OUT_ROW_W-1:0] row_index_o,
  output logic                     zero_norm_o,
  output logic [NVS_OUT_ROW_W-1:0] best_index_o,
  output logic                     done_res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [6:0]               cfg_data_i
);

  logic               push, pop, empty;
  nvs_rec_t           rec, head;
  logic [NVS_QCW-1:0] count;

  nvs_front #(.MaxLength(MaxLength), .MaxRows(MaxRows)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .last_row_i  (last_row_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_count_i   (count),
    .push_o      (push),
    .rec_o       (rec)
  );

  nvs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .count_o (count)
  );

  nvs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .score_o      (score_o),
    .row_index_o  (row_index_o),
    .zero_norm_o  (zero_norm_o),
    .best_index_o (best_index_o),
    .done_res_o   (done_res_o)
  );

endmodule

[test/tb.sv]
// testbench of the nearest vector search: self-checking stream test with a built-in predictor
`timescale 1ns / 100ps

module tb;
  import nvs_pkg::*;

  typedef struct {
    logic              cmd;
    logic signed [15:0] value;
    logic              last;
  } elem_t;

  typedef struct {
    logic signed [47:0] score;
    logic [9:0]         row;
    logic               zero;
    logic [9:0]         best;
    logic               done;
  } row_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic signed [15:0] value_i = '0;
  logic last_row_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [47:0] score_o;
  logic [9:0] row_index_o;
  logic zero_norm_o;
  logic [9:0] best_index_o;
  logic done_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  nvs_cfg_e cfg_index_i = CFG_METRIC;
  logic [6:0] cfg_data_i = '0;

  nearest_vector_search dut (.*);

  always #5 clk_i = ~clk_i;

  elem_t pending_elems[$];
  row_res_t expected_rows[$];
  int errors = 0;
  int sent = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  logic took = 1'b0;

  // predictor state
  nvs_metric_e p_metric;
  int p_len;
  longint q_store [NVS_MAX_LENGTH];
  longint unsigned q_norm;
  longint r_accum;
  longint unsigned r_norm;
  int elem_cnt, row_cnt, best_row, q_len;
  longint best_score;
  bit best_ok, searching;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cosine(longint dot, longint unsigned nq, longint unsigned nr);
    longint unsigned p, m, q, r;
    p = isqrt(nq << 16) * isqrt(nr << 16);
    m = dot < 0 ? -dot : dot;
    q = 0;
    r = m;
    if (p == 0 || m >= p) begin
      q = 64'd1 << 30;
    end else begin
      for (int i = 0; i < 46; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= p) begin
          r = r - p;
          q = q | 1;
        end
      end
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
    end
    return dot < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_search();
    elem_cnt = 0;
    r_accum = 0;
    r_norm = 0;
    row_cnt = 0;
    best_score = 0;
    best_row = 0;
    best_ok = 0;
  endfunction

  function automatic void score_elem(elem_t e);
    longint v, q, sc;
    bit zero, better;
    row_res_t res;
    v = e.value;
    zero = 0;
    if (!e.cmd) begin
      if (searching) begin
        searching = 0;
        q_len = 0;
        q_norm = 0;
        clear_search();
      end
      if (q_len < p_len) begin
        q_store[q_len] = v;
        q_norm = (q_norm + v * v) & 64'hFF_FFFF_FFFF;
        q_len++;
      end
      return;
    end
    if (!searching) begin
      searching = 1;
      clear_search();
    end
    q = elem_cnt < q_len ? q_store[elem_cnt] : 0;
    case (p_metric)
      METRIC_MANHATTAN: r_accum += q >= v ? q - v : v - q;
      METRIC_EUCLID:    r_accum += (q - v) * (q - v);
      default:          r_accum += q * v;
    endcase
    r_norm = (r_norm + v * v) & 64'hFF_FFFF_FFFF;
    elem_cnt++;
    if (elem_cnt < p_len) return;
    if (p_metric inside {METRIC_COSINE, METRIC_COSINE_X}) begin
      zero = q_norm == 0 || r_norm == 0;
      sc = zero ? 0 : cosine(r_accum, q_norm, r_norm);
      better = !zero && (!best_ok || sc > best_score);
    end else begin
      sc = r_accum;
      better = !best_ok || sc < best_score;
    end
    if (better) begin
      best_ok = 1;
      best_score = sc;
      best_row = row_cnt;
    end
    res.score = sc[47:0];
    res.row = row_cnt[9:0];
    res.zero = zero;
    res.best = best_ok ? best_row[9:0] : 10'd0;
    res.done = e.last;
    expected_rows.push_back(res);
    elem_cnt = 0;
    r_accum = 0;
    r_norm = 0;
    row_cnt = (row_cnt + 1) % NVS_MAX_ROWS;
    if (e.last) clear_search();
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      score_elem('{cmd_i, value_i, last_row_i});
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      if (pending_elems.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
        in_valid_i <= 1'b1;
        cmd_i <= pending_elems[0].cmd;
        value_i <= pending_elems[0].value;
        last_row_i <= pending_elems[0].last;
        void'(pending_elems.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && $urandom_range(99) < 22;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_rows.size() == 0) begin
        $display("%0t unexpected row result: score %0d row %0d", $time, score_o, row_index_o);
        errors++;
      end else begin
        row_res_t x;
        x = expected_rows.pop_front();
        if (score_o !== x.score) begin
          $display("%0t score: expected %0d actual %0d", $time, x.score, score_o);
          errors++;
        end
        if (row_index_o !== x.row) begin
          $display("%0t row_index: expected %0d actual %0d", $time, x.row, row_index_o);
          errors++;
        end
        if (zero_norm_o !== x.zero) begin
          $display("%0t zero_norm: expected %0d actual %0d", $time, x.zero, zero_norm_o);
          errors++;
        end
        if (best_index_o !== x.best) begin
          $display("%0t best_index: expected %0d actual %0d", $time, x.best, best_index_o);
          errors++;
        end
        if (done_res_o !== x.done) begin
          $display("%0t done_res: expected %0d actual %0d", $time, x.done, done_res_o);
          errors++;
        end
      end
    end
  end

  task automatic add(logic c, logic signed [15:0] v, logic l);
    pending_elems.push_back('{c, v, l});
    sent++;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    wait (pending_elems.size() == 0 && !in_valid_i && expected_rows.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(nvs_cfg_e idx, int data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 7'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_METRIC) p_metric = nvs_metric_e'(data[1:0]);
    else p_len = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(int m, int len);
    drain();
    write_reg(CFG_METRIC, m);
    write_reg(CFG_LENGTH, len);
  endtask

  task automatic add_query(int n, bit zero);
    for (int i = 0; i < n; i++) add(1'b0, zero ? 16'sd0 : pick_value(), 1'b0);
  endtask

  task automatic add_row(int len, bit last, bit zero);
    for (int i = 0; i < len; i++) add(1'b1, zero ? 16'sd0 : pick_value(), last);
  endtask

  initial begin
    int lens [8] = '{1, 2, 3, 4, 8, 16, 64, 5};
    int m, len, rows;
    p_metric = METRIC_MANHATTAN;
    p_len = 64;
    q_len = 0;
    q_norm = 0;
    searching = 0;
    clear_search();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full query fills the whole store, extremes in the row
    setup(METRIC_MANHATTAN, 64);
    for (int i = 0; i < 64; i++) add(1'b0, i[0] ? 16'sh7FFF : 16'sh8000, 1'b0);
    for (int i = 0; i < 64; i++) add(1'b1, i[0] ? 16'sh8000 : 16'sh7FFF, 1'b1);

    // short vectors: zero norms, extra and short queries, restart mid search
    setup(METRIC_COSINE_X, 4);
    add_query(6, 0);
    add_row(4, 0, 1);
    add_row(4, 1, 0);
    add_query(4, 1);
    add_row(4, 1, 0);
    setup(METRIC_EUCLID, 4);
    add_query(2, 0);
    add_row(4, 0, 0);
    add_query(4, 0);
    add_row(4, 0, 0);
    add_row(4, 1, 0);

    while (sent < 1550) begin
      m = $urandom_range(3);
      len = lens[$urandom_range(7)];
      if ($urandom_range(5) == 0) len = 64;
      setup(m, len);
      quiet = $urandom_range(5) == 0;
      if (!hold_req && m < 2 && len <= 2) hold_req = 1;
      add_query($urandom_range(9) == 0 ? $urandom_range(1, len) : len, $urandom_range(15) == 0);
      rows = len > 8 ? $urandom_range(1, 4) : $urandom_range(2, 12);
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(19) == 0) add_query($urandom_range(1, len), 0);
        add_row(len, r == rows - 1, $urandom_range(15) == 0);
      end
    end
    drain();
    quiet = 0;
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/core/nvs_pkg.sv
rtl/core/nvs_ram.sv
rtl/core/nvs_front.sv
rtl/core/nvs_queue.sv
rtl/core/nvs_back.sv
rtl/core/nearest_vector_search.sv
test/tb.sv
